// ===== sv/rsfp_pkg.sv =====
`default_nettype none
package rsfp_pkg;

   // channel count default and the fixed number of result lanes
   localparam int NUM_CHANNELS_DEFAULT = 4;
   localparam int OUT_CHANNELS = 4;

   // layout: first distance byte position for each format
   localparam int SHORT_BASE = 1;
   localparam int LONG_BASE  = 4;

   localparam logic [7:0] SHORT_HEADER  = 8'hFF;
   localparam logic [7:0] LONG_HEADER_0 = 8'h55;
   localparam logic [7:0] LONG_HEADER_1 = 8'hAA;

   // register map
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRAME_FORMAT = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_VALID_MM = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_VALID_MM = 2'd2;

   localparam logic        FORMAT_RESET  = 1'b0;
   localparam logic [15:0] MIN_MM_RESET  = 16'd25;
   localparam logic [15:0] MAX_MM_RESET  = 16'd4500;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_HEADER = 2'd1,
      STATUS_BAD_SUM    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] distance_a;
      logic [15:0] distance_b;
      logic [15:0] distance_c;
      logic [15:0] distance_d;
      logic        valid_a;
      logic        valid_b;
      logic        valid_c;
      logic        valid_d;
   } rsp_type;

   typedef struct packed {
      logic        frame_format;
      logic [15:0] min_valid_mm;
      logic [15:0] max_valid_mm;
   } cfg_type;

   // framer to output stage
   typedef struct packed {
      logic                            done;
      logic                            at_last;
      status_type                      status;
      logic [OUT_CHANNELS-1:0][15:0]   chan_mm;
   } frame_result_type;

endpackage
`default_nettype wire

// ===== sv/rsfp_csr.sv =====
`default_nettype none
module rsfp_csr (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               csr_write,
   input  wire [rsfp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire [rsfp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rsfp_pkg::cfg_type                 cfg
);

   rsfp_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_format <= rsfp_pkg::FORMAT_RESET;
         cfg_ff.min_valid_mm <= rsfp_pkg::MIN_MM_RESET;
         cfg_ff.max_valid_mm <= rsfp_pkg::MAX_MM_RESET;
      end else if (csr_write) begin
         unique case (csr_addr)
            rsfp_pkg::CSR_FRAME_FORMAT: cfg_ff.frame_format <= csr_wdata[0];
            rsfp_pkg::CSR_MIN_VALID_MM: cfg_ff.min_valid_mm <= csr_wdata;
            rsfp_pkg::CSR_MAX_VALID_MM: cfg_ff.max_valid_mm <= csr_wdata;
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== sv/rsfp_framer.sv =====
`default_nettype none
module rsfp_framer #(
   parameter int NUM_CHANNELS = rsfp_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          take,
   input  rsfp_pkg::req_type            req,
   input  rsfp_pkg::cfg_type            cfg,
   output rsfp_pkg::frame_result_type   result
);

   localparam int SHORT_LEN  = rsfp_pkg::SHORT_BASE + 2 * NUM_CHANNELS + 1;
   localparam int LONG_LEN   = rsfp_pkg::LONG_BASE + 2 * NUM_CHANNELS + 1;
   localparam int POS_W      = $clog2(LONG_LEN);
   localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [POS_W-1:0] SHORT_LAST = POS_W'(SHORT_LEN - 1);
   localparam logic [POS_W-1:0] LONG_LAST  = POS_W'(LONG_LEN - 1);
   localparam logic [POS_W-1:0] SHORT_B    = POS_W'(rsfp_pkg::SHORT_BASE);
   localparam logic [POS_W-1:0] LONG_B     = POS_W'(rsfp_pkg::LONG_BASE);
   localparam logic [POS_W-1:0] SPAN       = POS_W'(2 * NUM_CHANNELS);
   localparam logic [POS_W-1:0] POS_ZERO   = '0;
   localparam logic [POS_W-1:0] POS_ONE    = POS_W'(1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              in_frame_ff, in_frame_in;
   logic              good_ff, good_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        hold_ff, hold_in;
   logic [15:0]       chan_ff [NUM_CHANNELS];

   logic [POS_W-1:0]  pos_eff, last, base, off;
   logic              good_eff, active, done, in_span, chan_we;
   logic [7:0]        sum_eff;
   logic [CH_W-1:0]   ch;

   always_comb begin
      last     = cfg.frame_format ? LONG_LAST : SHORT_LAST;
      base     = cfg.frame_format ? LONG_B : SHORT_B;
      pos_eff  = req.frame_start ? POS_ZERO : pos_ff;
      good_eff = req.frame_start | good_ff;
      sum_eff  = req.frame_start ? 8'h00 : sum_ff;
      active   = req.frame_start | in_frame_ff;
      done     = take & active & (pos_eff >= last);
      in_span  = (pos_eff >= base) && (pos_eff < base + SPAN);
      off      = pos_eff - base;
      ch       = off[CH_W:1];
      chan_we  = take & active & ~done & in_span & off[0]
               & ({{(32-CH_W){1'b0}}, ch} < 32'(NUM_CHANNELS));

      pos_in      = pos_ff;
      in_frame_in = in_frame_ff;
      good_in     = good_ff;
      sum_in      = sum_ff;
      hold_in     = hold_ff;

      if (take && active) begin
         if (done) begin
            in_frame_in = 1'b0;
            pos_in      = POS_ZERO;
            good_in     = good_eff;
            sum_in      = sum_eff;
         end else begin
            in_frame_in = 1'b1;
            pos_in      = pos_eff + POS_ONE;
            sum_in      = sum_eff + req.rx_byte;
            good_in     = good_eff;
            if (cfg.frame_format) begin
               if (pos_eff == POS_ZERO && req.rx_byte != rsfp_pkg::LONG_HEADER_0)
                  good_in = 1'b0;
               if (pos_eff == POS_ONE && req.rx_byte != rsfp_pkg::LONG_HEADER_1)
                  good_in = 1'b0;
            end else if (pos_eff == POS_ZERO && req.rx_byte != rsfp_pkg::SHORT_HEADER) begin
               good_in = 1'b0;
            end
            if (in_span && !off[0])
               hold_in = req.rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         in_frame_ff <= 1'b0;
         good_ff     <= 1'b1;
         sum_ff      <= '0;
         hold_ff     <= '0;
      end else begin
         pos_ff      <= pos_in;
         in_frame_ff <= in_frame_in;
         good_ff     <= good_in;
         sum_ff      <= sum_in;
         hold_ff     <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (chan_we)
         chan_ff[ch] <= {hold_ff, req.rx_byte};
   end

   always_comb begin
      result.done    = done;
      result.at_last = in_frame_ff && (pos_ff >= last);
      priority if (!good_eff)
         result.status = rsfp_pkg::STATUS_BAD_HEADER;
      else if (sum_eff != req.rx_byte)
         result.status = rsfp_pkg::STATUS_BAD_SUM;
      else
         result.status = rsfp_pkg::STATUS_OK;
      for (int k = 0; k < rsfp_pkg::OUT_CHANNELS; k++) begin
         if (k < NUM_CHANNELS)
            result.chan_mm[k] = chan_ff[k];
         else
            result.chan_mm[k] = 16'h0000;
      end
   end

endmodule
`default_nettype wire

// ===== sv/rsfp_out.sv =====
`default_nettype none
module rsfp_out #(
   parameter int NUM_CHANNELS = rsfp_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire                          clock,
   input  wire                          reset,
   input  rsfp_pkg::frame_result_type   result,
   input  rsfp_pkg::cfg_type            cfg,
   input  wire                          rsp_stall,
   output logic                         rsp_valid,
   output rsfp_pkg::rsp_type            rsp_data
);

   logic                 rsp_valid_ff, rsp_valid_in;
   rsfp_pkg::rsp_type    rsp_data_ff, rsp_data_in;
   logic [rsfp_pkg::OUT_CHANNELS-1:0][15:0] d;
   logic [rsfp_pkg::OUT_CHANNELS-1:0]       v;
   logic                 ok;

   always_comb begin
      ok = (result.status == rsfp_pkg::STATUS_OK);
      for (int k = 0; k < rsfp_pkg::OUT_CHANNELS; k++) begin
         d[k] = ok ? result.chan_mm[k] : 16'h0000;
         // lanes beyond the channel count never flag
         v[k] = ok && (k < NUM_CHANNELS)
                   && (result.chan_mm[k] >= cfg.min_valid_mm)
                   && (result.chan_mm[k] <= cfg.max_valid_mm);
      end
      rsp_data_in.status     = result.status;
      rsp_data_in.distance_a = d[0];
      rsp_data_in.distance_b = d[1];
      rsp_data_in.distance_c = d[2];
      rsp_data_in.distance_d = d[3];
      rsp_data_in.valid_a    = v[0];
      rsp_data_in.valid_b    = v[1];
      rsp_data_in.valid_c    = v[2];
      rsp_data_in.valid_d    = v[3];

      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (result.done)
         rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (result.done)
         rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== sv/ranging_sensor_frame_parser.sv =====
`default_nettype none
// Latency: a result appears in rsp_data the cycle after its checksum byte transfers.
// Throughput: one byte per cycle while the input is not stalled; the frame state updates once per byte in one pass.
// The input stalls only while a held result is stalled at the output and the next byte would be a checksum.
// Reset (synchronous, active high) closes any open frame, drops a held result and
// loads format 0, min 25 mm, max 4500 mm; channel registers are not cleared.
module ranging_sensor_frame_parser #(
   parameter int NUM_CHANNELS = rsfp_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   // byte channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  rsfp_pkg::req_type                 req_data,
   // result channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output rsfp_pkg::rsp_type                 rsp_data,
   // register writes
   input  wire                               csr_write,
   input  wire [rsfp_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire [rsfp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   rsfp_pkg::cfg_type          cfg;
   rsfp_pkg::frame_result_type result;
   logic                       take;

   rsfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // A checksum byte needs a free output slot (empty, or draining this cycle).
   // Frames are at least four bytes long, so only that byte ever has to wait.
   assign req_stall = rsp_valid & rsp_stall & result.at_last;
   assign take      = req_valid & ~req_stall;

   rsfp_framer #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_framer (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .req    (req_data),
      .cfg    (cfg),
      .result (result)
   );

   // range flags and zeroing of bad frames sit ahead of the result register
   rsfp_out #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .cfg       (cfg),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== test/frame_parser_checker.sv =====
`timescale 1ns / 1ps
module frame_parser_checker #(
   parameter int NUM_CHANNELS = rsfp_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   input  wire                             req_stall,
   input  rsfp_pkg::req_type               req_data,
   input  wire                             rsp_valid,
   input  wire                             rsp_stall,
   input  rsfp_pkg::rsp_type               rsp_data,
   input  wire                             csr_write,
   input  wire [rsfp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire [rsfp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              frames_pending,
   output int                              ok_seen,
   output int                              bad_header_seen,
   output int                              bad_sum_seen
);

   // register copy
   logic        fmt_long;
   logic [15:0] lo_mm;
   logic [15:0] hi_mm;

   // framer state copy
   int          byte_pos;
   logic        frame_open;
   logic        header_ok;
   logic [7:0]  byte_sum;
   logic [7:0]  high_hold;
   logic [15:0] chan_mm [NUM_CHANNELS];

   rsfp_pkg::rsp_type expected_frames [$];

   function automatic string describe(input rsfp_pkg::rsp_type r);
      return $sformatf("status=%0d dist=%0d/%0d/%0d/%0d in_range=%b%b%b%b",
                       r.status, r.distance_a, r.distance_b, r.distance_c,
                       r.distance_d, r.valid_a, r.valid_b, r.valid_c, r.valid_d);
   endfunction

   task automatic queue_expected(input rsfp_pkg::rsp_type r);
      expected_frames.insert(expected_frames.size(), r);
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic start);
      int                                last_pos;
      int                                base_pos;
      int                                off;
      int                                k;
      rsfp_pkg::rsp_type                 r;
      logic [15:0]                       lane [rsfp_pkg::OUT_CHANNELS];
      logic [rsfp_pkg::OUT_CHANNELS-1:0] hit;
      if (start) begin
         byte_pos   = 0;
         frame_open = 1'b1;
         header_ok  = 1'b1;
         byte_sum   = 8'd0;
      end else if (!frame_open) begin
         return;
      end
      // layout follows the register value at this byte
      last_pos = fmt_long ? rsfp_pkg::LONG_BASE + 2 * NUM_CHANNELS
                          : rsfp_pkg::SHORT_BASE + 2 * NUM_CHANNELS;
      base_pos = fmt_long ? rsfp_pkg::LONG_BASE : rsfp_pkg::SHORT_BASE;
      if (byte_pos >= last_pos) begin
         for (k = 0; k < rsfp_pkg::OUT_CHANNELS; k++) begin
            lane[k] = 16'd0;
            hit[k]  = 1'b0;
         end
         r = '0;
         if (!header_ok) begin
            r.status = rsfp_pkg::STATUS_BAD_HEADER;
         end else if (byte_sum != b) begin
            r.status = rsfp_pkg::STATUS_BAD_SUM;
         end else begin
            r.status = rsfp_pkg::STATUS_OK;
            for (k = 0; k < rsfp_pkg::OUT_CHANNELS && k < NUM_CHANNELS; k++) begin
               lane[k] = chan_mm[k];
               hit[k]  = (chan_mm[k] >= lo_mm) && (chan_mm[k] <= hi_mm);
            end
         end
         r.distance_a = lane[0];
         r.distance_b = lane[1];
         r.distance_c = lane[2];
         r.distance_d = lane[3];
         r.valid_a    = hit[0];
         r.valid_b    = hit[1];
         r.valid_c    = hit[2];
         r.valid_d    = hit[3];
         queue_expected(r);
         frame_open = 1'b0;
         byte_pos   = 0;
         return;
      end
      byte_sum = byte_sum + b;
      if (!fmt_long) begin
         if (byte_pos == 0 && b != rsfp_pkg::SHORT_HEADER) header_ok = 1'b0;
      end else begin
         if (byte_pos == 0 && b != rsfp_pkg::LONG_HEADER_0) header_ok = 1'b0;
         if (byte_pos == 1 && b != rsfp_pkg::LONG_HEADER_1) header_ok = 1'b0;
      end
      if (byte_pos >= base_pos && byte_pos < base_pos + 2 * NUM_CHANNELS) begin
         off = byte_pos - base_pos;
         if (off % 2 == 0) high_hold = b;
         else chan_mm[off / 2] = {high_hold, b};
      end
      byte_pos = byte_pos + 1;
   endtask

   task automatic check_result(input rsfp_pkg::rsp_type got);
      rsfp_pkg::rsp_type want;
      if (expected_frames.size() == 0) begin
         mismatch_count++;
         $display("%0t: result with nothing expected: %s", $time, describe(got));
         return;
      end
      want = expected_frames.pop_front();
      if (want.status == rsfp_pkg::STATUS_OK) ok_seen++;
      else if (want.status == rsfp_pkg::STATUS_BAD_HEADER) bad_header_seen++;
      else bad_sum_seen++;
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: result mismatch", $time);
         $display("   expected %s", describe(want));
         $display("   actual   %s", describe(got));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fmt_long        = rsfp_pkg::FORMAT_RESET;
         lo_mm           = rsfp_pkg::MIN_MM_RESET;
         hi_mm           = rsfp_pkg::MAX_MM_RESET;
         byte_pos        = 0;
         frame_open      = 1'b0;
         header_ok       = 1'b1;
         byte_sum        = 8'd0;
         high_hold       = 8'd0;
         for (int k = 0; k < NUM_CHANNELS; k++) chan_mm[k] = 16'd0;
         expected_frames.delete();
         mismatch_count  = 0;
         ok_seen         = 0;
         bad_header_seen = 0;
         bad_sum_seen    = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (req_valid && !req_stall) parse_byte(req_data.rx_byte, req_data.frame_start);
         if (csr_write) begin
            case (csr_addr)
               rsfp_pkg::CSR_FRAME_FORMAT: fmt_long = csr_wdata[0];
               rsfp_pkg::CSR_MIN_VALID_MM: lo_mm = csr_wdata;
               rsfp_pkg::CSR_MAX_VALID_MM: hi_mm = csr_wdata;
               default: ;
            endcase
         end
      end
      frames_pending = expected_frames.size();
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

   localparam int CHANNELS  = rsfp_pkg::NUM_CHANNELS_DEFAULT;
   localparam int SHORT_LEN = rsfp_pkg::SHORT_BASE + 2 * CHANNELS + 1;
   localparam int LONG_LEN  = rsfp_pkg::LONG_BASE + 2 * CHANNELS + 1;

   // dut-facing signals; the ones the bench drives are known from time zero
   logic                              clock;
   logic                              reset      = 1'b1;
   logic                              req_valid  = 1'b0;
   logic                              req_stall;
   rsfp_pkg::req_type                 req_data   = '0;
   logic                              rsp_valid;
   logic                              rsp_stall  = 1'b0;
   rsfp_pkg::rsp_type                 rsp_data;
   logic                              csr_write  = 1'b0;
   logic [rsfp_pkg::CSR_ADDR_W-1:0]   csr_addr   = rsfp_pkg::CSR_FRAME_FORMAT;
   logic [rsfp_pkg::CSR_DATA_W-1:0]   csr_wdata  = '0;

   // checker outputs
   int mismatch_count;
   int frames_pending;
   int ok_seen;
   int bad_header_seen;
   int bad_sum_seen;

   // stimulus bookkeeping
   logic        cfg_fmt = rsfp_pkg::FORMAT_RESET;
   logic [15:0] cfg_lo  = rsfp_pkg::MIN_MM_RESET;
   logic [15:0] cfg_hi  = rsfp_pkg::MAX_MM_RESET;
   logic        quiet   = 1'b0;     // no gaps, no stalls while set
   int          bytes_sent    = 0;
   int          frames_sent   = 0;
   int          settings_used = 0;

   // result-side stall pattern
   logic        stall_on   = 1'b0;
   int          stall_left = 0;

   ranging_sensor_frame_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   frame_parser_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write       (csr_write),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .frames_pending  (frames_pending),
      .ok_seen         (ok_seen),
      .bad_header_seen (bad_header_seen),
      .bad_sum_seen    (bad_sum_seen)
   );

   // 10 ns clock, starts low
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly short idle stretches, now and then a long one
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = int'($urandom_range(0, 99));
      if (r < 50) return 0;
      if (r < 85) return int'($urandom_range(1, 3));
      if (r < 97) return int'($urandom_range(4, 10));
      return int'($urandom_range(20, 60));
   endfunction

   // distances lean on the edges of the current valid window
   function automatic logic [15:0] pick_distance();
      case ($urandom_range(0, 9))
         0: return cfg_lo;
         1: return cfg_lo - 16'd1;
         2: return cfg_hi;
         3: return cfg_hi + 16'd1;
         4: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // result stall: random on/off stretches, changed only at the falling edge
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_on   = ($urandom_range(0, 9) < 4);
         stall_left = pick_gap() + 1;
      end
      stall_left = stall_left - 1;
      rsp_stall <= stall_on && !quiet;
   end

   // one byte transfer; entered and left at a falling edge.
   // valid stays high straight into the next byte when there is no gap.
   task automatic send_byte(input logic [7:0] b, input logic start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{rx_byte: b, frame_start: start};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   // random bytes inside an open frame, keeping the additive checksum
   task automatic send_payload(input int count, inout logic [7:0] acc);
      logic [7:0] b;
      for (int k = 0; k < count; k++) begin
         b   = 8'($urandom_range(0, 255));
         acc = acc + b;
         send_byte(b, 1'b0);
      end
   endtask

   // full or cut frame; keep = 0 sends all bytes, otherwise only the first keep
   task automatic send_frame(input logic fmt, input logic bad_hdr, input logic bad_sum,
                             input int keep, input logic [15:0] d0, input logic [15:0] d1,
                             input logic [15:0] d2, input logic [15:0] d3);
      logic [7:0]  fb [LONG_LEN];
      logic [15:0] dv [4];
      logic [7:0]  sum;
      logic [7:0]  flip;
      int          spot;
      int          fill;
      fill = 0;
      dv   = '{d0, d1, d2, d3};
      if (fmt) begin
         fb[0] = rsfp_pkg::LONG_HEADER_0;
         fb[1] = rsfp_pkg::LONG_HEADER_1;
         fb[2] = 8'($urandom_range(0, 255));   // don't-care bytes
         fb[3] = 8'($urandom_range(0, 255));
         fill  = 4;
      end else begin
         fb[0] = rsfp_pkg::SHORT_HEADER;
         fill  = 1;
      end
      for (int k = 0; k < CHANNELS; k++) begin
         fb[fill]     = dv[k][15:8];
         fb[fill + 1] = dv[k][7:0];
         fill         = fill + 2;
      end
      if (bad_hdr) begin
         spot     = fmt ? int'($urandom_range(0, 1)) : 0;
         flip     = 8'($urandom_range(1, 255));
         fb[spot] = fb[spot] ^ flip;
      end
      sum = 8'd0;
      for (int k = 0; k < fill; k++) sum = sum + fb[k];
      flip     = 8'($urandom_range(1, 255));
      fb[fill] = bad_sum ? sum ^ flip : sum;
      fill     = fill + 1;
      if (keep == 0 || keep > fill) keep = fill;
      for (int k = 0; k < keep; k++) send_byte(fb[k], k == 0);
      frames_sent++;
   endtask

   // drop valid, drain every expected result, then allow for the output
   // stage before touching the registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (frames_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // all three registers, one write per cycle; format upper bits are don't-care
   task automatic set_config(input logic fmt, input logic [15:0] lo, input logic [15:0] hi);
      csr_write <= 1'b1;
      csr_addr  <= rsfp_pkg::CSR_FRAME_FORMAT;
      csr_wdata <= (16'($urandom_range(0, 65535)) & 16'hFFFE) | {15'd0, fmt};
      @(negedge clock);
      csr_addr  <= rsfp_pkg::CSR_MIN_VALID_MM;
      csr_wdata <= lo;
      @(negedge clock);
      csr_addr  <= rsfp_pkg::CSR_MAX_VALID_MM;
      csr_wdata <= hi;
      @(negedge clock);
      csr_write <= 1'b0;
      cfg_fmt = fmt;
      cfg_lo  = lo;
      cfg_hi  = hi;
      settings_used++;
   endtask

   initial begin : stimulus
      logic [7:0]  acc;
      logic [15:0] lo;
      logic [15:0] hi;
      int          pick;
      int          target;
      int          flen;
      int          n;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed: reset settings, short layout ----
      // window edges: 24 below, 25 and 4500 on, 4501 above
      send_frame(1'b0, 1'b0, 1'b0, 0, 16'd24, 16'd25, 16'd4500, 16'd4501);
      // stray bytes with no frame open are ignored
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_frame(1'b0, 1'b1, 1'b0, 0, 16'd100, 16'd200, 16'd300, 16'd400);
      send_frame(1'b0, 1'b0, 1'b1, 0, 16'd100, 16'd200, 16'd300, 16'd400);
      // header and checksum both wrong: header status wins
      send_frame(1'b0, 1'b1, 1'b1, 0, 16'd100, 16'd200, 16'd300, 16'd400);
      // new frame start mid-frame drops the partial one
      send_frame(1'b0, 1'b0, 1'b0, 5, 16'd1, 16'd2, 16'd3, 16'd4);
      send_frame(1'b0, 1'b0, 1'b0, 0, 16'h0000, 16'hFFFF, 16'h8000, 16'h00FF);
      wait_idle();

      // format switched short -> long in the middle of a frame
      acc = rsfp_pkg::SHORT_HEADER;
      send_byte(rsfp_pkg::SHORT_HEADER, 1'b1);
      send_payload(3, acc);
      wait_idle();
      set_config(1'b1, cfg_lo, cfg_hi);
      send_payload(LONG_LEN - 5, acc);
      send_byte(acc, 1'b0);
      wait_idle();

      // long layout, widest window
      set_config(1'b1, 16'h0000, 16'hFFFF);
      send_frame(1'b1, 1'b0, 1'b0, 0, 16'h0000, 16'hFFFF, 16'h1234, 16'hABCD);
      send_frame(1'b1, 1'b1, 1'b0, 0, 16'd5, 16'd6, 16'd7, 16'd8);
      send_frame(1'b1, 1'b0, 1'b1, 0, 16'd5, 16'd6, 16'd7, 16'd8);
      wait_idle();

      // format switched long -> short past the short checksum spot: next byte closes
      acc = rsfp_pkg::LONG_HEADER_0 + rsfp_pkg::LONG_HEADER_1;
      send_byte(rsfp_pkg::LONG_HEADER_0, 1'b1);
      send_byte(rsfp_pkg::LONG_HEADER_1, 1'b0);
      send_payload(LONG_LEN - 4, acc);
      wait_idle();
      set_config(1'b0, cfg_lo, cfg_hi);
      send_byte(acc, 1'b0);
      wait_idle();

      // minimum above maximum: nothing in range
      set_config(1'b0, 16'd5000, 16'd100);
      send_frame(1'b0, 1'b0, 1'b0, 0, 16'd100, 16'd5000, 16'd2000, 16'd0);
      wait_idle();

      // ---- random phases ----
      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 3))
            0: begin
               lo = 16'h0000;
               hi = 16'hFFFF;
            end
            1: begin
               lo = 16'($urandom_range(0, 65535));
               hi = 16'($urandom_range(0, 65535));
            end
            2: begin
               lo = 16'($urandom_range(5000, 65535));
               hi = 16'($urandom_range(0, 4999));
            end
            default: begin
               lo = 16'($urandom_range(0, 2000));
               hi = 16'($urandom_range(2000, 65535));
            end
         endcase
         set_config(1'(phase % 2), lo, hi);
         quiet  = (phase % 3 == 2);   // one phase in three runs back to back
         flen   = cfg_fmt ? LONG_LEN : SHORT_LEN;
         target = bytes_sent + 230;
         while (bytes_sent < target) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 68)
               send_frame(cfg_fmt, 1'b0, 1'b0, 0, pick_distance(), pick_distance(),
                          pick_distance(), pick_distance());
            else if (pick < 76)
               send_frame(cfg_fmt, 1'b1, 1'b0, 0, pick_distance(), pick_distance(),
                          pick_distance(), pick_distance());
            else if (pick < 84)
               send_frame(cfg_fmt, 1'b0, 1'b1, 0, pick_distance(), pick_distance(),
                          pick_distance(), pick_distance());
            else if (pick < 87)
               send_frame(cfg_fmt, 1'b1, 1'b1, 0, pick_distance(), pick_distance(),
                          pick_distance(), pick_distance());
            else if (pick < 94)
               send_frame(cfg_fmt, 1'($urandom_range(0, 1)), 1'b0,
                          int'($urandom_range(1, flen - 1)),
                          pick_distance(), pick_distance(), pick_distance(),
                          pick_distance());
            else begin
               // noise: random bytes, occasional frame start
               n = int'($urandom_range(1, 12));
               for (int k = 0; k < n; k++)
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
         end
         // close any frame the noise left open before the next register write
         send_frame(cfg_fmt, 1'b0, 1'b0, 0, pick_distance(), pick_distance(),
                    pick_distance(), pick_distance());
         wait_idle();
      end

      quiet = 1'b0;
      repeat (8) @(negedge clock);
      $display("Sent %0d bytes (%0d frames) under %0d register settings, both layouts",
               bytes_sent, frames_sent, settings_used);
      $display("Checked %0d results: %0d ok, %0d bad header, %0d bad checksum",
               ok_seen + bad_header_seen + bad_sum_seen, ok_seen, bad_header_seen,
               bad_sum_seen);
      if (mismatch_count == 0 && frames_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #10_000_000;
      $display("Timeout with %0d results outstanding", frames_pending);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== ranging_sensor_frame_parser.f =====
sv/rsfp_pkg.sv
sv/rsfp_csr.sv
sv/rsfp_framer.sv
sv/rsfp_out.sv
sv/ranging_sensor_frame_parser.sv
test/frame_parser_checker.sv
test/testbench.sv
